// ===== rtl/centered_running_average_defines.svh =====
// assertion macros for the centered running average block
// used by the top level; expects clk and arst_n in scope
`ifndef CENTERED_RUNNING_AVERAGE_DEFINES_SVH
`define CENTERED_RUNNING_AVERAGE_DEFINES_SVH

// consequent checked in the same cycle
`define CRA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define CRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cra_pkg.sv =====
// shared constants and types for the centered running average block
// no dependencies
`default_nettype none

package cra_pkg;

	// window store and register widths
	localparam int MAX_WINDOW = 64;
	localparam int WIN_AW     = $clog2(MAX_WINDOW);
	localparam int WIN_W      = 7;
	localparam int LEN_W      = 17;
	localparam int MAX_SERIES = 65536;
	localparam int INDEX_W    = 16;

	// configuration register indexes
	localparam logic [0:0] REG_WINDOW = 1'b0;
	localparam logic [0:0] REG_SERIES = 1'b1;

	typedef logic [LEN_W-1:0] len_t;

endpackage

`default_nettype wire

// ===== rtl/cra_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module cra_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/cra_div.sv =====
// rounded signed mean: (|sum| + n/2) / n, one quotient bit per cycle
// depends on cra_pkg
`default_nettype none

module cra_div #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         start,
	input  wire logic signed [SAMPLE_BITS+cra_pkg::LEN_W-1:0] dividend,
	input  wire cra_pkg::len_t                                divisor,
	output logic                                              busy,
	output logic                                              done,
	output logic signed [SAMPLE_BITS-1:0]                     quotient
);

	localparam int SUM_W = SAMPLE_BITS + cra_pkg::LEN_W;
	localparam int CNT_W = $clog2(SAMPLE_BITS);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] dsh_q;
	logic [SAMPLE_BITS-1:0] q_q;
	logic             neg_q;

	logic             neg_in;
	logic [SUM_W-1:0] mag;
	logic [SUM_W-1:0] rem_init;
	logic [SUM_W-1:0] dsh_init;
	logic             ge;

	// operand setup: magnitude plus half the divisor for round to nearest
	assign neg_in   = dividend[SUM_W-1];
	assign mag      = neg_in ? (~dividend + SUM_W'(1)) : dividend;
	assign rem_init = mag + SUM_W'(divisor >> 1);
	assign dsh_init = SUM_W'(divisor) << (SAMPLE_BITS - 1);
	assign ge       = (rem_q >= dsh_q);

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SAMPLE_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	// restoring division, quotient known to fit in sample width
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dsh_q <= dsh_init;
			q_q   <= '0;
			neg_q <= neg_in;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			q_q   <= {q_q[SAMPLE_BITS-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? (~q_q + SAMPLE_BITS'(1)) : q_q;

endmodule

`default_nettype wire

// ===== rtl/centered_running_average.sv =====
// channel  | signals                                      | direction
// ---------+----------------------------------------------+----------
// in       | in_valid, in_stall, sample                   | sink
// out      | out_valid, out_stall, mean_value, out_index, | source
//          | run_last, series_done                        |
// cfg      | cfg_write, cfg_index, cfg_data               | sink
//
// a sample that gives no result passes through accept and update; one that gives a result
// passes through accept, update, the divider and the push. each flush result passes through
// window read, a subtract when a sample leaves the window, the divider and the push;
// the last sample of a series gives up to window/2 + 1 results.
// reset clears counters, sum and handshake state; the window ram needs no clearing pass.
// a stalled output holds its item; the next result waits in push with the input stalled.
// depends on cra_pkg, cra_ram, cra_div, centered_running_average_defines.svh
`default_nettype none

`include "centered_running_average_defines.svh"

module centered_running_average #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [0:0]                        cfg_index,
	input  wire logic [cra_pkg::LEN_W-1:0]         cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]     sample,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [SAMPLE_BITS-1:0]          mean_value,
	output logic [cra_pkg::INDEX_W-1:0]            out_index,
	output logic                                   run_last,
	output logic                                   series_done
);

	localparam int SUM_W = SAMPLE_BITS + cra_pkg::LEN_W;
	localparam int LEN_W = cra_pkg::LEN_W;
	localparam int WIN_W = cra_pkg::WIN_W;
	localparam int AW    = cra_pkg::WIN_AW;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_PUSH = 3'd3;
	localparam logic [2:0] ST_FLU  = 3'd4;
	localparam logic [2:0] ST_FSUB = 3'd5;

	logic [2:0]                state_q;
	logic [WIN_W-1:0]          w_q;
	cra_pkg::len_t             len_q;
	cra_pkg::len_t             taken_q;
	cra_pkg::len_t             given_q;
	cra_pkg::len_t             start_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                      last_q;
	logic [cra_pkg::INDEX_W-1:0] pidx_q;
	logic                      pdone_q;
	logic                      prl_q;
	logic                      out_valid_q;
	logic signed [SAMPLE_BITS-1:0] mean_q;
	logic [cra_pkg::INDEX_W-1:0] oidx_q;
	logic                      rl_q;
	logic                      sdone_q;

	logic                      in_acc;
	logic                      out_free;
	logic                      out_load;
	logic                      wmode;
	cra_pkg::len_t             w_l;
	cra_pkg::len_t             h_l;
	logic                      need_sub;
	logic                      last;
	logic                      emit;
	cra_pkg::len_t             taken_p1;
	cra_pkg::len_t             given_p1;
	cra_pkg::len_t             start_p1;
	cra_pkg::len_t             cnt_w;
	cra_pkg::len_t             start_init;
	cra_pkg::len_t             back_addr;
	logic [LEN_W:0]            ns_base;
	logic [LEN_W:0]            ns;
	logic                      flu_sub;
	logic signed [SUM_W-1:0]   ext_x;
	logic signed [SUM_W-1:0]   ext_rd;
	logic signed [SUM_W-1:0]   sum_upd;
	logic signed [SUM_W-1:0]   sum_fsub;
	logic [WIN_W-1:0]          wv;
	logic [WIN_W-1:0]          w_eff;
	cra_pkg::len_t             len_eff;

	logic                      ram_we;
	logic [AW-1:0]             ram_raddr;
	logic [SAMPLE_BITS-1:0]    ram_rdata;

	logic                      div_start;
	logic signed [SUM_W-1:0]   div_dividend;
	cra_pkg::len_t             div_divisor;
	logic                      div_busy;
	logic                      div_done;
	logic signed [SAMPLE_BITS-1:0] div_quot;

	// handshakes
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == ST_PUSH) && out_free;

	// configuration clipping
	assign wv    = cfg_data[WIN_W-1:0];
	assign w_eff = (wv == '0) ? WIN_W'(1) :
		((wv > WIN_W'(cra_pkg::MAX_WINDOW)) ? WIN_W'(cra_pkg::MAX_WINDOW) : wv);
	assign len_eff = (cfg_data == '0) ? LEN_W'(1) :
		((cfg_data > LEN_W'(cra_pkg::MAX_SERIES)) ? LEN_W'(cra_pkg::MAX_SERIES) : cfg_data);

	// window arithmetic
	assign w_l        = LEN_W'(w_q);
	assign h_l        = LEN_W'(w_q >> 1);
	assign wmode      = (w_l < len_q);
	assign need_sub   = wmode && (taken_q >= w_l);
	assign last       = (taken_q == len_q - LEN_W'(1));
	assign emit       = (taken_q >= h_l);
	assign taken_p1   = taken_q + LEN_W'(1);
	assign given_p1   = given_q + LEN_W'(1);
	assign start_p1   = start_q + LEN_W'(1);
	assign cnt_w      = (taken_p1 < w_l) ? taken_p1 : w_l;
	assign start_init = (taken_p1 >= w_l) ? (taken_p1 - w_l) : '0;
	assign back_addr  = taken_q - w_l;

	// flush: oldest sample still inside the window of the next output
	assign ns_base = {1'b0, given_q} + {1'b0, h_l} + (LEN_W+1)'(1);
	assign ns      = (ns_base >= {1'b0, w_l}) ? (ns_base - {1'b0, w_l}) : '0;
	assign flu_sub = ({1'b0, start_q} < ns);

	// running sum updates
	assign ext_x    = {{(SUM_W-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q};
	assign ext_rd   = {{(SUM_W-SAMPLE_BITS){ram_rdata[SAMPLE_BITS-1]}}, ram_rdata};
	assign sum_upd  = sum_q - (need_sub ? ext_rd : '0) + ext_x;
	assign sum_fsub = sum_q - ext_rd;

	// ram write enable, read address and divider launch per state
	always_comb begin
		div_start    = 1'b0;
		div_dividend = sum_q;
		div_divisor  = len_q;
		ram_we       = 1'b0;
		ram_raddr    = back_addr[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				ram_raddr = back_addr[AW-1:0];
			end
			ST_UPD: begin
				ram_we = wmode;
				if (!wmode) begin
					div_start    = last;
					div_dividend = sum_upd;
					div_divisor  = len_q;
				end else begin
					div_start    = emit;
					div_dividend = sum_upd;
					div_divisor  = cnt_w;
				end
			end
			ST_FLU: begin
				ram_raddr = start_q[AW-1:0];
				if (!flu_sub) begin
					div_start    = 1'b1;
					div_dividend = sum_q;
					div_divisor  = len_q - start_q;
				end
			end
			ST_FSUB: begin
				div_start    = 1'b1;
				div_dividend = sum_fsub;
				div_divisor  = len_q - start_p1;
			end
			default: begin
			end
		endcase
	end

	// control state, counters and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			w_q         <= WIN_W'(1);
			len_q       <= LEN_W'(1);
			taken_q     <= '0;
			given_q     <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					sum_q <= sum_upd;
					if (!wmode) begin
						if (last) begin
							state_q <= ST_DIV;
						end else begin
							taken_q <= taken_p1;
							state_q <= ST_IDLE;
						end
					end else if (emit) begin
						given_q <= given_p1;
						state_q <= ST_DIV;
					end else begin
						taken_q <= taken_p1;
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						if (prl_q) begin
							if (last_q) begin
								taken_q <= '0;
								given_q <= '0;
								sum_q   <= '0;
							end else begin
								taken_q <= taken_p1;
							end
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_FLU;
						end
					end
				end
				ST_FLU: begin
					if (flu_sub) begin
						state_q <= ST_FSUB;
					end else begin
						given_q <= given_p1;
						state_q <= ST_DIV;
					end
				end
				ST_FSUB: begin
					sum_q   <= sum_fsub;
					given_q <= given_p1;
					state_q <= ST_DIV;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// register write abandons the series in progress
			if (cfg_write) begin
				unique case (cfg_index)
					cra_pkg::REG_WINDOW: w_q   <= w_eff;
					cra_pkg::REG_SERIES: len_q <= len_eff;
				endcase
				taken_q <= '0;
				given_q <= '0;
				sum_q   <= '0;
			end

			// output register valid
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item data, flush position, pending result tags and output data
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= sample;
		end
		unique case (state_q)
			ST_UPD: begin
				last_q  <= last;
				start_q <= start_init;
				if (!wmode) begin
					pidx_q  <= '0;
					pdone_q <= 1'b1;
					prl_q   <= 1'b1;
				end else begin
					pidx_q  <= given_q[cra_pkg::INDEX_W-1:0];
					pdone_q <= (given_q == len_q - LEN_W'(1));
					prl_q   <= !last || (given_p1 == len_q);
				end
			end
			ST_FLU, ST_FSUB: begin
				if (state_q == ST_FSUB) begin
					start_q <= start_p1;
				end
				pidx_q  <= given_q[cra_pkg::INDEX_W-1:0];
				pdone_q <= (given_q == len_q - LEN_W'(1));
				prl_q   <= (given_q == len_q - LEN_W'(1));
			end
			default: begin
			end
		endcase
		if (out_load) begin
			mean_q  <= div_quot;
			oidx_q  <= pidx_q;
			rl_q    <= prl_q;
			sdone_q <= pdone_q;
		end
	end

	// sample window store, written during update only, read address given the cycle before use
	cra_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (cra_pkg::MAX_WINDOW)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (taken_q[AW-1:0]),
		.wdata (x_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// shared divider for all window means
	cra_div #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign out_valid   = out_valid_q;
	assign mean_value  = mean_q;
	assign out_index   = oidx_q;
	assign run_last    = rl_q;
	assign series_done = sdone_q;

	// checks on control sequencing
	`CRA_ASSERT_NEXT(a_accept_goes_busy, in_valid && !in_stall, state_q == ST_UPD, "accepted item did not enter update")
	`CRA_ASSERT_SAME(a_div_not_overrun, div_start, !div_busy, "divider restarted while busy")
	`CRA_ASSERT_SAME(a_div_done_waited, div_done, state_q == ST_DIV, "divider finished outside wait state")
	`CRA_ASSERT_SAME(a_taken_in_range, state_q == ST_IDLE, taken_q < len_q, "sample count beyond series length")

endmodule

`default_nettype wire
